/* rtl/dhn_pkg.sv */
// Shared constants and helpers for the DNS host name normaliser.
// No dependencies; imported by dns_hostname_normalizer_core.
`default_nettype none

package dhn_pkg;

   // Length limits
   localparam logic [8:0] MaxTotal   = 9'd253;
   localparam logic [6:0] MaxLabel   = 7'd63;
   localparam logic [8:0] TotalSat   = 9'd511;
   localparam logic [6:0] LabelSat   = 7'd127;
   localparam logic [2:0] CountSat   = 3'd7;
   localparam logic [2:0] QuadDots   = 3'd3;
   localparam logic [8:0] OctetMax   = 9'd255;
   localparam logic [8:0] OctetSat   = 9'd256;

   // Character codes
   localparam logic [7:0] ChDot      = 8'h2E;
   localparam logic [7:0] ChHyphen   = 8'h2D;
   localparam logic [7:0] ChStar     = 8'h2A;
   localparam logic [7:0] ChUpperA   = 8'h41;
   localparam logic [7:0] ChUpperZ   = 8'h5A;
   localparam logic [7:0] ChLowerA   = 8'h61;
   localparam logic [7:0] ChLowerZ   = 8'h7A;
   localparam logic [7:0] ChZero     = 8'h30;
   localparam logic [7:0] ChNine     = 8'h39;
   localparam logic [7:0] CaseOffset = 8'h20;

   // Byte class as seen by the validator
   typedef enum logic [2:0] {
      CLS_DOT,
      CLS_UPPER,
      CLS_LOWER,
      CLS_DIGIT,
      CLS_HYPHEN,
      CLS_OTHER
   } char_class_type;

   // Fold ASCII upper case to lower case, all else unchanged
   function automatic logic [7:0] fold_case(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= ChUpperA && b <= ChUpperZ) r = b + CaseOffset;
      return r;
   endfunction

endpackage : dhn_pkg

`default_nettype wire

/* rtl/dns_hostname_normalizer_core.sv */
// DNS host name normaliser: byte stream case folding, trailing dot strip, verdict.
// Depends on dhn_pkg.
`default_nettype none

// Takes a host name one byte per request (req_in_last marks the final byte) and
// returns one registered result per request, with the byte folded to lower case. A
// trailing dot on the final byte comes back with rsp_out_keep low. On the final
// result rsp_name_ok gives the verdict: the name is refused when empty after
// stripping, longer than 253 bytes, has an empty label or one over 63 bytes, holds
// a byte other than letters, digits, '-' and '.', or is an IPv4 dotted quad. A new
// request is taken in every cycle unless rsp_ready stalls: the only stage is the
// result register, and req_ready is high whenever it is empty or being drained in
// the same cycle. State clears after each final byte, so names follow back to back.
module dns_hostname_normalizer_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_keep,
   output logic            rsp_out_last,
   output logic            rsp_name_ok
);
   import dhn_pkg::*;

   // Name state
   logic [6:0]  label_length_ff, label_length_in;
   logic [8:0]  total_length_ff, total_length_in;
   logic        bad_seen_ff, bad_seen_in;
   logic [2:0]  label_count_ff, label_count_in;
   logic        all_numeric_ff, all_numeric_in;
   logic [8:0]  octet_value_ff, octet_value_in;
   logic        leading_zero_ff, leading_zero_in;

   // Result register
   logic        rsp_valid_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_keep_ff, rsp_last_ff, rsp_ok_ff;

   logic           accept;
   logic           stripped;
   logic           verdict;
   char_class_type cls;
   logic [3:0]     digit;
   logic [11:0]    octet_calc;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign stripped  = req_in_last && (req_in_byte == ChDot);
   assign digit     = req_in_byte[3:0];

   // Times ten by shift and add, plus the new digit
   assign octet_calc = {octet_value_ff, 3'b000} + {2'b00, octet_value_ff, 1'b0}
                       + {8'h00, digit};

   // Classify the incoming byte
   always_comb begin
      case (req_in_byte) inside
         ChDot:                cls = CLS_DOT;
         ChHyphen:             cls = CLS_HYPHEN;
         [ChUpperA:ChUpperZ]:  cls = CLS_UPPER;
         [ChLowerA:ChLowerZ]:  cls = CLS_LOWER;
         [ChZero:ChNine]:      cls = CLS_DIGIT;
         default:              cls = CLS_OTHER;
      endcase
   end

   // Absorb the byte, form the verdict, clear after the final byte
   always_comb begin
      label_length_in = label_length_ff;
      total_length_in = total_length_ff;
      bad_seen_in     = bad_seen_ff;
      label_count_in  = label_count_ff;
      all_numeric_in  = all_numeric_ff;
      octet_value_in  = octet_value_ff;
      leading_zero_in = leading_zero_ff;

      if (!stripped) begin
         if (total_length_ff != TotalSat) total_length_in = total_length_ff + 9'd1;
         if (total_length_in > MaxTotal) bad_seen_in = 1'b1;

         case (cls)
            CLS_DOT: begin
               if (label_length_ff == 7'd0) bad_seen_in = 1'b1;
               label_length_in = 7'd0;
               if (label_count_ff != CountSat) label_count_in = label_count_ff + 3'd1;
               octet_value_in  = 9'd0;
               leading_zero_in = 1'b0;
            end
            CLS_UPPER, CLS_LOWER, CLS_DIGIT, CLS_HYPHEN: begin
               if (cls == CLS_DIGIT) begin
                  if (leading_zero_ff) all_numeric_in = 1'b0;
                  if (label_length_ff == 7'd0 && digit == 4'd0) leading_zero_in = 1'b1;
                  if (octet_calc > {3'b000, OctetMax}) begin
                     all_numeric_in = 1'b0;
                     octet_value_in = OctetSat;
                  end else begin
                     octet_value_in = octet_calc[8:0];
                  end
               end else begin
                  all_numeric_in = 1'b0;
               end
               if (label_length_ff != LabelSat) label_length_in = label_length_ff + 7'd1;
               if (label_length_in > MaxLabel) bad_seen_in = 1'b1;
            end
            default: begin
               bad_seen_in    = 1'b1;
               all_numeric_in = 1'b0;
            end
         endcase
      end

      verdict = 1'b0;
      if (req_in_last) begin
         verdict = !bad_seen_in && (total_length_in != 9'd0) &&
                   (total_length_in <= MaxTotal) && (label_length_in != 7'd0) &&
                   !(all_numeric_in && label_count_in == QuadDots);
         label_length_in = 7'd0;
         total_length_in = 9'd0;
         bad_seen_in     = 1'b0;
         label_count_in  = 3'd0;
         all_numeric_in  = 1'b1;
         octet_value_in  = 9'd0;
         leading_zero_in = 1'b0;
      end
   end

   // State and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         label_length_ff <= 7'd0;
         total_length_ff <= 9'd0;
         bad_seen_ff     <= 1'b0;
         label_count_ff  <= 3'd0;
         all_numeric_ff  <= 1'b1;
         octet_value_ff  <= 9'd0;
         leading_zero_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            label_length_ff <= label_length_in;
            total_length_ff <= total_length_in;
            bad_seen_ff     <= bad_seen_in;
            label_count_ff  <= label_count_in;
            all_numeric_ff  <= all_numeric_in;
            octet_value_ff  <= octet_value_in;
            leading_zero_ff <= leading_zero_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff    <= 1'b0;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_byte_ff <= fold_case(req_in_byte);
         rsp_keep_ff <= !stripped;
         rsp_last_ff <= req_in_last;
         rsp_ok_ff   <= verdict;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_keep = rsp_keep_ff;
   assign rsp_out_last = rsp_last_ff;
   assign rsp_name_ok  = rsp_ok_ff;

   // Checks
   a_ok_only_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_last |-> !rsp_name_ok)
      else $error("verdict raised on a non-final result");

   a_drop_is_dot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_keep |-> rsp_out_last && rsp_out_byte == ChDot)
      else $error("dropped byte is not a trailing dot");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_in_last |=> total_length_ff == 9'd0 && label_length_ff == 7'd0
                                && all_numeric_ff && !bad_seen_ff)
      else $error("state not cleared after final byte");

   a_no_upper_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_out_byte >= ChUpperA && rsp_out_byte <= ChUpperZ))
      else $error("upper case byte on result");

endmodule : dns_hostname_normalizer_core

`default_nettype wire
